### sv/bba_pkg.sv
package bba_pkg;

	localparam int MAP_BYTES_DEF = 512;

	localparam int MAP_BITS_W = 13;
	localparam int INDEX_W    = 12;
	localparam int OP_W       = 2;
	localparam int CEIL_W     = 11;

	localparam logic [OP_W-1:0] OP_SET   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_TEST  = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND  = 2'd3;

	localparam logic [7:0] FULL_BYTE = 8'hFF;

	localparam logic [2:0]            REG_MAP_BITS  = 3'd0;
	localparam logic [MAP_BITS_W-1:0] MAP_BITS_RST  = 13'd4096;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_FIND
	} state_t;

	typedef struct packed {
		logic clr_en;
		logic load;
		logic exec;
		logic scan;
		logic find_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_end;
		logic scan_hit;
	} dp_sts_t;

	// position of the lowest zero bit; 0 when the byte is full
	function automatic logic [2:0] first_zero(input logic [7:0] b);
		logic [2:0] pos;
		logic       hit;
		pos = 3'd0;
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!hit && !b[i]) begin
				pos = 3'(i);
				hit = 1'b1;
			end
		end
		return pos;
	endfunction

endpackage

### sv/bba_ctrl.sv
module bba_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bba_pkg::OP_W-1:0]  op,
	input  bba_pkg::dp_sts_t          sts,
	output bba_pkg::dp_cmd_t          cmd,
	output logic                      busy
);
	import bba_pkg::*;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_nx = (op == OP_FIND) ? ST_FIND : ST_EXEC;
			end
			ST_EXEC: begin
				state_nx = ST_IDLE;
			end
			ST_FIND: begin
				if (sts.scan_end || sts.scan_hit) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_FIND: begin
				cmd.scan = 1'b1;
				cmd.find_out = sts.scan_end || sts.scan_hit;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// an access op goes from the exec state back to idle in the next cycle
	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_IDLE)
		else $error("exec state held");

	// no item is taken while the clearing pass runs
	a_no_load_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !cmd.load && busy)
		else $error("item taken during clear");

	// hold the search until it hits or runs off the scanned range
	a_find_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIND && !cmd.find_out |=> state_q == ST_FIND)
		else $error("search left early");

endmodule

### sv/bba_dp.sv
module bba_dp #(
	parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bba_pkg::dp_cmd_t                cmd,
	output bba_pkg::dp_sts_t                sts,
	input  logic [bba_pkg::OP_W-1:0]        op,
	input  logic [bba_pkg::INDEX_W-1:0]     blk_index,
	input  logic [bba_pkg::MAP_BITS_W-1:0]  map_bits,
	output logic                            done,
	output logic                            bit_value,
	output logic                            free_found,
	output logic [bba_pkg::INDEX_W-1:0]     free_index,
	output logic                            out_of_range
);
	import bba_pkg::*;

	localparam int AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CNT_W = $clog2(MAP_BYTES + 1);
	localparam int LIM_W = (CNT_W > CEIL_W) ? CNT_W : CEIL_W;
	localparam logic [AW-1:0]    LAST_ADDR = AW'(MAP_BYTES - 1);
	localparam logic [LIM_W-1:0] LIM_MAX   = LIM_W'(MAP_BYTES);

	logic [7:0]       mem [MAP_BYTES];
	logic [7:0]       rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic             wr_en;

	logic [OP_W-1:0]    op_q;
	logic [INDEX_W-1:0] idx_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [AW-1:0]      clr_q;

	logic [MAP_BITS_W:0] ceil_sum;
	logic [LIM_W-1:0]    ceil_bytes;
	logic [LIM_W-1:0]    nbytes;
	logic [LIM_W-1:0]    byte_idx;
	logic [7:0]          mask;
	logic                oor;
	logic                found;
	logic [CNT_W+2:0]    fi_full;

	logic                done_q;
	logic                bit_value_q;
	logic                free_found_q;
	logic [INDEX_W-1:0]  free_index_q;
	logic                oor_q;

	// scanned byte count, capped at the store size
	assign ceil_sum   = {1'b0, map_bits} + (MAP_BITS_W+1)'(7);
	assign ceil_bytes = LIM_W'(ceil_sum[MAP_BITS_W:3]);
	assign nbytes     = (ceil_bytes >= LIM_MAX) ? LIM_MAX : ceil_bytes;

	assign byte_idx = LIM_W'(idx_q[INDEX_W-1:3]);
	assign mask     = 8'(1) << idx_q[2:0];
	assign oor      = byte_idx >= nbytes;

	assign sts.clr_last = (clr_q == LAST_ADDR);
	assign sts.scan_end = LIM_W'(ptr_q) >= nbytes;
	assign sts.scan_hit = (rd_data_q != FULL_BYTE);

	assign found   = !sts.scan_end && sts.scan_hit;
	assign fi_full = {ptr_q, first_zero(rd_data_q)};

	always_comb begin
		if (cmd.load) begin
			rd_addr = (op == OP_FIND) ? '0 : AW'(blk_index[INDEX_W-1:3]);
		end else begin
			rd_addr = AW'(ptr_q + CNT_W'(1));
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = 8'h00;
		if (cmd.clr_en) begin
			wr_en = 1'b1;
		end else if (cmd.exec && !oor && (op_q == OP_SET || op_q == OP_CLEAR)) begin
			wr_en   = 1'b1;
			wr_addr = AW'(idx_q[INDEX_W-1:3]);
			wr_data = (op_q == OP_SET) ? (rd_data_q | mask) : (rd_data_q & ~mask);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en && !sts.clr_last) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// hold the item, advance the scan pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			idx_q <= blk_index;
			ptr_q <= '0;
		end else if (cmd.scan && !cmd.find_out) begin
			ptr_q <= ptr_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.exec || cmd.find_out;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			bit_value_q  <= (op_q == OP_TEST) && !oor && ((rd_data_q & mask) != 8'h00);
			free_found_q <= 1'b0;
			free_index_q <= '0;
			oor_q        <= oor;
		end else if (cmd.find_out) begin
			bit_value_q  <= 1'b0;
			free_found_q <= found;
			free_index_q <= found ? INDEX_W'(fi_full) : '0;
			oor_q        <= 1'b0;
		end
	end

	assign done         = done_q;
	assign bit_value    = bit_value_q;
	assign free_found   = free_found_q;
	assign free_index   = free_index_q;
	assign out_of_range = oor_q;

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(cmd.exec || cmd.find_out))
		else $error("result without finished op");

	a_find_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(free_found && out_of_range) && !(free_found && bit_value))
		else $error("find and access flags mixed");

	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !wr_en)
		else $error("map written during search");

endmodule

### sv/bitmap_block_allocator.sv
// Bitmap block allocator: one bit per block, 1 used, 0 free, kept in a
// byte-wide store of MAP_BYTES entries.
// Command channel: drive op and blk_index with start; the item is taken at
// the edge where start is high and busy is low. op selects set, clear, test
// or find-lowest-free. Find ignores blk_index.
// Result channel: done pulses for one cycle with bit_value, free_found,
// free_index and out_of_range; the receiver cannot stall it, so sample it
// on that cycle.
// Sequencing: set, clear and test read the byte, then modify and write it
// back; done is registered and follows in the next cycle, and a new item can
// be taken in that same cycle. Find reads one byte per cycle from byte 0 and
// stops at the first byte with a free bit, or when no bit is free after
// min(ceil(map_bits/8), MAP_BYTES) bytes; done follows in the next cycle.
// The store has one read port and one write port.
// Reset: a clearing pass writes every byte to free with busy high; map_bits
// resets to 4096. The user must write map_bits through the APB port
// (address 0) only while no item is in flight; the block does not enforce it.
module bitmap_block_allocator #(
	parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [bba_pkg::OP_W-1:0]     op,
	input  logic [bba_pkg::INDEX_W-1:0]  blk_index,
	output logic                         done,
	output logic                         bit_value,
	output logic                         free_found,
	output logic [bba_pkg::INDEX_W-1:0]  free_index,
	output logic                         out_of_range,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import bba_pkg::*;

	logic [MAP_BITS_W-1:0] map_bits_q;
	dp_cmd_t               cmd;
	dp_sts_t               sts;

	// config register: write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_bits_q <= MAP_BITS_RST;
		end else if (psel && penable && pwrite && paddr == REG_MAP_BITS) begin
			map_bits_q <= pwdata[MAP_BITS_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_MAP_BITS) ? {{(32-MAP_BITS_W){1'b0}}, map_bits_q} : '0;

	bba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bba_dp #(
		.MAP_BYTES (MAP_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.blk_index    (blk_index),
		.map_bits     (map_bits_q),
		.done         (done),
		.bit_value    (bit_value),
		.free_found   (free_found),
		.free_index   (free_index),
		.out_of_range (out_of_range)
	);

endmodule

### verif/bba_checker.sv
module bba_checker #(
	parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [bba_pkg::OP_W-1:0]     op,
	input  logic [bba_pkg::INDEX_W-1:0]  blk_index,
	input  logic                         done,
	input  logic                         bit_value,
	input  logic                         free_found,
	input  logic [bba_pkg::INDEX_W-1:0]  free_index,
	input  logic                         out_of_range,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	input  logic [31:0]                  prdata,
	input  logic                         pready,
	output int                           errors,
	output int                           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	typedef struct packed {
		logic               bit_value;
		logic               free_found;
		logic [INDEX_W-1:0] free_index;
		logic               out_of_range;
	} alloc_result_t;

	logic [7:0]            shadow_map [MAP_BYTES];
	logic [MAP_BITS_W-1:0] map_bits_cfg;
	alloc_result_t         pending_results [$];

	function automatic int unsigned scanned_bytes();
		int unsigned n;
		n = (int'(map_bits_cfg) + 7) / 8;
		return (n > MAP_BYTES) ? MAP_BYTES : n;
	endfunction

	// apply one command to the shadow bitmap and return its result
	function automatic alloc_result_t apply_command(input logic [OP_W-1:0] code,
			input logic [INDEX_W-1:0] idx);
		alloc_result_t res;
		int unsigned   nbytes;
		int unsigned   byte_sel;
		res = '0;
		nbytes = scanned_bytes();
		byte_sel = int'(idx) / 8;
		if (code == OP_FIND) begin
			for (int unsigned i = 0; i < nbytes && !res.free_found; i++) begin
				if (shadow_map[i] != FULL_BYTE) begin
					for (int b = 0; b < 8 && !res.free_found; b++) begin
						if (!shadow_map[i][b]) begin
							res.free_found = 1'b1;
							res.free_index = INDEX_W'(i * 8 + b);
						end
					end
				end
			end
		end else if (byte_sel >= nbytes) begin
			res.out_of_range = 1'b1;
		end else begin
			case (code)
				OP_SET:   shadow_map[byte_sel][idx[2:0]] = 1'b1;
				OP_CLEAR: shadow_map[byte_sel][idx[2:0]] = 1'b0;
				default:  res.bit_value = shadow_map[byte_sel][idx[2:0]];
			endcase
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t oldest;
		if (!arst_n) begin
			foreach (shadow_map[i]) shadow_map[i] = 8'h00;
			map_bits_cfg = MAP_BITS_RST;
			pending_results.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result with no item outstanding");
					errors++;
				end else begin
					oldest = pending_results.pop_front();
					check_field("bit_value", 32'(oldest.bit_value), 32'(bit_value));
					check_field("free_found", 32'(oldest.free_found), 32'(free_found));
					check_field("free_index", 32'(oldest.free_index), 32'(free_index));
					check_field("out_of_range", 32'(oldest.out_of_range),
						32'(out_of_range));
				end
			end
			if (psel && penable && pready && paddr == REG_MAP_BITS) begin
				if (pwrite)
					map_bits_cfg = pwdata[MAP_BITS_W-1:0];
				else
					check_field("prdata", {{(32-MAP_BITS_W){1'b0}}, map_bits_cfg}, prdata);
			end
			if (start && !busy)
				pending_results.push_back(apply_command(op, blk_index));
			outstanding <= pending_results.size();
		end
	end

endmodule

### verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bba_pkg::*;

	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 3_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [OP_W-1:0]       op = OP_SET;
	logic [INDEX_W-1:0]    blk_index = '0;
	logic                  done;
	logic                  bit_value;
	logic                  free_found;
	logic [INDEX_W-1:0]    free_index;
	logic                  out_of_range;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [2:0]            paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	int                    check_errors;
	int                    outstanding;
	int                    cycle_count = 0;
	int                    items_sent = 0;
	int                    burst_left = 0;
	logic [MAP_BITS_W-1:0] map_bits_now = MAP_BITS_RST;

	bitmap_block_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .op(op), .blk_index(blk_index),
		.done(done), .bit_value(bit_value), .free_found(free_found),
		.free_index(free_index), .out_of_range(out_of_range),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// watches both channels, predicts every result and counts mismatches
	bba_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .op(op), .blk_index(blk_index),
		.done(done), .bit_value(bit_value), .free_found(free_found),
		.free_index(free_index), .out_of_range(out_of_range),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.errors(check_errors), .outstanding(outstanding)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// number of bits the find covers: whole bytes, capped at the store size
	function automatic int unsigned scan_bits();
		int unsigned n;
		n = (int'(map_bits_now) + 7) / 8;
		if (n > MAP_BYTES_DEF)
			n = MAP_BYTES_DEF;
		return n * 8;
	endfunction

	// mostly indexes inside the scanned range, the rest anywhere in 12 bits
	function automatic logic [INDEX_W-1:0] pick_index(input int unsigned scan);
		if (scan == 0 || $urandom_range(0, 3) == 0)
			return INDEX_W'($urandom);
		return INDEX_W'($urandom_range(0, scan - 1));
	endfunction

	// wait until the block is idle and every result is in
	task automatic wait_idle();
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
	endtask

	// present one item, hold it until taken, then maybe go quiet for a while
	task automatic send(input logic [OP_W-1:0] code, input logic [INDEX_W-1:0] idx);
		int gap;
		op <= code;
		blk_index <= idx;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// end of burst: drop start and wiggle the payload while idle
			start <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			repeat (gap) begin
				op <= OP_W'($urandom);
				blk_index <= INDEX_W'($urandom);
				@(posedge clk);
			end
			// now and then hold off until the block has drained
			if ($urandom_range(0, 9) == 0)
				wait_idle();
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 12);
		end
	endtask

	// write map_bits while idle, then read it back for the checker
	task automatic set_map_bits(input logic [MAP_BITS_W-1:0] value);
		start <= 1'b0;
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_MAP_BITS;
		pwdata <= {(32 - MAP_BITS_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// go straight into a read setup phase
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		map_bits_now = value;
	endtask

	initial begin
		int              directed_end;
		int              phase_end;
		int unsigned     scan;
		int unsigned     len;
		int unsigned     base;
		logic [MAP_BITS_W-1:0] mb;

		// hold reset, then let the clearing pass finish inside set_map_bits
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		set_map_bits(13'd4096);

		// directed: empty map, both ends of the index range, a full first byte
		send(OP_FIND, 12'hFFF);
		send(OP_TEST, 12'd0);
		send(OP_SET, 12'd0);
		send(OP_TEST, 12'd0);
		send(OP_FIND, 12'd0);
		send(OP_SET, 12'd4095);
		send(OP_TEST, 12'd4095);
		send(OP_CLEAR, 12'd4095);
		send(OP_TEST, 12'd4095);
		for (int i = 1; i < 8; i++)
			send(OP_SET, INDEX_W'(i));
		// byte 0 is full now: the find has to skip it
		send(OP_FIND, 12'd0);
		send(OP_CLEAR, 12'd3);
		send(OP_FIND, 12'd0);
		send(OP_TEST, 12'd2048);

		// empty map: nothing scanned, every index out of range
		set_map_bits(13'd0);
		send(OP_SET, 12'd5);
		send(OP_FIND, 12'd0);
		send(OP_TEST, 12'd0);

		// one-bit map: find may land past map_bits inside byte 0
		set_map_bits(13'd1);
		send(OP_FIND, 12'd0);
		send(OP_SET, 12'd8);
		send(OP_SET, 12'd3);
		// map full
		send(OP_FIND, 12'd0);
		directed_end = items_sent;

		// random phases, each under its own map size
		while (items_sent < directed_end + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       mb = 13'd0;
				1:       mb = MAP_BITS_W'($urandom_range(1, 8));
				2, 3, 4: mb = MAP_BITS_W'($urandom_range(9, 64));
				5:       mb = MAP_BITS_W'($urandom_range(65, 400));
				6:       mb = 13'd4096;
				7:       mb = 13'd8191;
				8:       mb = MAP_BITS_W'($urandom_range(4097, 8190));
				default: mb = MAP_BITS_W'($urandom_range(1, 4096));
			endcase
			set_map_bits(mb);
			scan = scan_bits();
			phase_end = items_sent + $urandom_range(40, 100);
			while (items_sent < phase_end) begin
				case ($urandom_range(0, 3))
					0: begin
						// allocation run: look for a hole, then take the next bit
						len = (scan == 0) ? 4 : $urandom_range(8, 40);
						if (scan != 0 && len > scan)
							len = scan;
						base = (scan == 0 || $urandom_range(0, 1) == 0) ? 0
							: $urandom_range(0, scan - 1);
						for (int unsigned k = 0; k < len; k++) begin
							send(OP_FIND, INDEX_W'($urandom));
							send(OP_SET, INDEX_W'(base + k));
						end
					end
					1: begin
						// release a few blocks and look for the lowest hole
						repeat ($urandom_range(1, 6))
							send(OP_CLEAR, pick_index(scan));
						send(OP_FIND, INDEX_W'($urandom));
						send(OP_TEST, pick_index(scan));
					end
					default: send(OP_W'($urandom), pick_index(scan));
				endcase
			end
		end

		// drain, then give the longest find time to show up
		start <= 1'b0;
		wait_idle();
		repeat (MAP_BYTES_DEF + 8) @(posedge clk);
		if (check_errors == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
